@@ rtl/core/swfd_pkg.sv @@
// Shared types and constants of the sync word frame deframer.
package swfd_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned WORD_W        = 16;
	localparam int unsigned PAYLOAD_BYTES = 14;
	localparam int unsigned IDX_W         = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic signed [WORD_W-1:0] sword_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		sword_t left_pwm;
		sword_t right_pwm;
		sword_t left_encoder;
		sword_t right_encoder;
		sword_t left_speed;
		sword_t right_speed;
		word_t  end_word;
	} frame_t;

endpackage

@@ rtl/core/swfd_byte_if.sv @@
// Handshake channel that carries one received byte per word.
interface swfd_byte_if;
	import swfd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/swfd_frame_if.sv @@
// Handshake channel that carries one decoded frame per word.
interface swfd_frame_if;
	import swfd_pkg::*;

	logic   valid;
	logic   ready;
	sword_t left_pwm;
	sword_t right_pwm;
	sword_t left_encoder;
	sword_t right_encoder;
	sword_t left_speed;
	sword_t right_speed;
	word_t  end_word;

	modport source (output valid, output left_pwm, output right_pwm, output left_encoder,
		output right_encoder, output left_speed, output right_speed, output end_word,
		input ready);
	modport sink (input valid, input left_pwm, input right_pwm, input left_encoder,
		input right_encoder, input left_speed, input right_speed, input end_word,
		output ready);
endinterface

@@ rtl/core/sync_word_frame_deframer.sv @@
// Top level of the sync word frame deframer: hunts for a start word and emits decoded frames.
//
// Channel  Direction  Word
// rx       in         one received byte
// frame    out        seven 16-bit fields of one decoded frame
// cfg      in         start word write, 16 bits
//
// One byte is accepted per cycle while the output is not stalled; the hunt compare and the
// frame store update finish in the cycle that accepts the byte.
// A frame appears in the output register in the cycle after its last byte is accepted.
// Reset clears the hunt state, the byte index and the output valid flag.
// Input is held off only while a frame waits in the output register and the sink stalls.
module sync_word_frame_deframer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  swfd_pkg::word_t       cfg_data,
	swfd_byte_if.sink             rx,
	swfd_frame_if.source          frame
);
	import swfd_pkg::*;

	word_t  sync_word_q;
	logic   collecting_q;
	byte_t  prev_byte_q;
	logic   prev_valid_q;
	idx_t   byte_idx_q;
	byte_t  frame_store_q [PAYLOAD_BYTES-1];
	logic   out_valid_q;
	frame_t frame_q;

	logic   accept;
	logic   match;
	logic   emit;
	frame_t frame_d;

	assign rx.ready = !out_valid_q || frame.ready;
	assign accept   = rx.valid && rx.ready;
	assign match    = !collecting_q && prev_valid_q && ({prev_byte_q, rx.rx_byte} == sync_word_q);
	assign emit     = accept && collecting_q && (byte_idx_q == LAST_IDX);

	always_comb begin
		frame_d.left_pwm      = {frame_store_q[0],  frame_store_q[1]};
		frame_d.right_pwm     = {frame_store_q[2],  frame_store_q[3]};
		frame_d.left_encoder  = {frame_store_q[4],  frame_store_q[5]};
		frame_d.right_encoder = {frame_store_q[6],  frame_store_q[7]};
		frame_d.left_speed    = {frame_store_q[8],  frame_store_q[9]};
		frame_d.right_speed   = {frame_store_q[10], frame_store_q[11]};
		frame_d.end_word      = {frame_store_q[12], rx.rx_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= '0;
		end else if (cfg_we) begin
			sync_word_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			prev_byte_q  <= '0;
			prev_valid_q <= 1'b0;
			byte_idx_q   <= '0;
		end else if (accept) begin
			if (!collecting_q) begin
				if (match) begin
					collecting_q <= 1'b1;
					byte_idx_q   <= '0;
					prev_valid_q <= 1'b0;
					prev_byte_q  <= '0;
				end else begin
					prev_byte_q  <= rx.rx_byte;
					prev_valid_q <= 1'b1;
				end
			end else if (byte_idx_q == LAST_IDX) begin
				collecting_q <= 1'b0;
				byte_idx_q   <= '0;
				prev_valid_q <= 1'b0;
				prev_byte_q  <= '0;
			end else begin
				byte_idx_q <= byte_idx_q + idx_t'(1);
			end
		end
	end

	// The payload bytes land in the store; the last one goes straight into the frame.
	always_ff @(posedge clk) begin
		if (accept && collecting_q && (byte_idx_q != LAST_IDX)) begin
			frame_store_q[byte_idx_q] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_q <= frame_d;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.left_pwm      = frame_q.left_pwm;
	assign frame.right_pwm     = frame_q.right_pwm;
	assign frame.left_encoder  = frame_q.left_encoder;
	assign frame.right_encoder = frame_q.right_encoder;
	assign frame.left_speed    = frame_q.left_speed;
	assign frame.right_speed   = frame_q.right_speed;
	assign frame.end_word      = frame_q.end_word;

`ifndef SYNTHESIS
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (out_valid_q && !frame.ready))
		else $error("input stalled without a pending frame");

	a_window_empty_while_collecting: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> !prev_valid_q)
		else $error("hunt window not empty during collection");

	a_idx_zero_while_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		!collecting_q |-> (byte_idx_q == '0))
		else $error("byte index nonzero while hunting");

	a_frame_after_collection: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(collecting_q) && !collecting_q))
		else $error("frame emitted without a completed collection");
`endif

endmodule

@@ tb/swfd_frame_checker.sv @@
// Checker that predicts decoded frames from accepted bytes and compares them with the output.
module swfd_frame_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  swfd_pkg::word_t cfg_data,
	swfd_byte_if            rx,
	swfd_frame_if           frame,
	output int              fail_count,
	output int              frames_pending
);
	import swfd_pkg::*;

	word_t  start_word;
	logic   collecting;
	byte_t  last_byte;
	logic   last_byte_valid;
	idx_t   fill;
	byte_t  payload [PAYLOAD_BYTES];
	frame_t expected_frames [$];
	frame_t exp_frame;
	logic [PAYLOAD_BYTES*BYTE_W-1:0] flat;

	function automatic void check_field(input string name, input word_t exp_v,
		input word_t act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_word      = '0;
			collecting      = 1'b0;
			last_byte       = '0;
			last_byte_valid = 1'b0;
			fill            = '0;
			fail_count      = 0;
			expected_frames.delete();
			frames_pending  = 0;
		end else begin
			if (cfg_we) begin
				start_word = cfg_data;
			end
			if (rx.valid && rx.ready) begin
				if (!collecting) begin
					if (last_byte_valid && {last_byte, rx.rx_byte} == start_word) begin
						collecting      = 1'b1;
						fill            = '0;
						last_byte_valid = 1'b0;
						last_byte       = '0;
					end else begin
						last_byte       = rx.rx_byte;
						last_byte_valid = 1'b1;
					end
				end else begin
					payload[fill] = rx.rx_byte;
					if (fill == LAST_IDX) begin
						flat = '0;
						for (int k = 0; k < PAYLOAD_BYTES; k++) begin
							flat = {flat[PAYLOAD_BYTES*BYTE_W-BYTE_W-1:0], payload[k]};
						end
						expected_frames.push_back(frame_t'(flat));
						collecting      = 1'b0;
						fill            = '0;
						last_byte_valid = 1'b0;
						last_byte       = '0;
					end else begin
						fill = fill + 1'b1;
					end
				end
			end
			if (frame.valid && frame.ready) begin
				if (expected_frames.size() == 0) begin
					$error("Frame word arrived with no frame expected.");
					fail_count++;
				end else begin
					exp_frame = expected_frames.pop_front();
					check_field("left_pwm", exp_frame.left_pwm, frame.left_pwm);
					check_field("right_pwm", exp_frame.right_pwm, frame.right_pwm);
					check_field("left_encoder", exp_frame.left_encoder, frame.left_encoder);
					check_field("right_encoder", exp_frame.right_encoder, frame.right_encoder);
					check_field("left_speed", exp_frame.left_speed, frame.left_speed);
					check_field("right_speed", exp_frame.right_speed, frame.right_speed);
					check_field("end_word", exp_frame.end_word, frame.end_word);
				end
			end
			frames_pending = expected_frames.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top of the sync word frame deframer: byte stimulus, sink stalls and verdict.
module tb_top;
	import swfd_pkg::*;

	logic  clk      = 1'b0;
	logic  arst_n   = 1'b0;
	logic  cfg_we   = 1'b0;
	word_t cfg_data = '0;

	bit    tx_gaps_on     = 1'b1;
	bit    sink_stalls_on = 1'b1;
	int    fail_count;
	int    frames_pending;
	word_t start_word;
	int    phase;
	int    sent;
	int    pick;
	int    burst;

	byte_t directed_bytes [19] = '{
		8'h5A, 8'h00, 8'h00,
		8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
		8'hFF, 8'hFE, 8'h01, 8'h00, 8'hAA, 8'h00,
		8'h00, 8'h00
	};

	swfd_byte_if  rx_ch ();
	swfd_frame_if frame_ch ();

	always #5 clk = ~clk;

	sync_word_frame_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rx       (rx_ch),
		.frame    (frame_ch)
	);

	swfd_frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.rx             (rx_ch),
		.frame          (frame_ch),
		.fail_count     (fail_count),
		.frames_pending (frames_pending)
	);

	task automatic send_byte(input byte_t value);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= value;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_frame();
		send_byte(start_word[15:8]);
		send_byte(start_word[7:0]);
		repeat (PAYLOAD_BYTES) send_byte(byte_t'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (frames_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_start_word(input word_t value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin
		int n;
		frame_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			n = sink_stalls_on ? $urandom_range(0, 6) : 0;
			if (n > 0) begin
				frame_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			frame_ch.ready <= 1'b1;
			do @(posedge clk); while (!(frame_ch.valid && frame_ch.ready));
			@(negedge clk);
		end
	end

	initial begin
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_bytes[i]) begin
			send_byte(directed_bytes[i]);
		end
		// The block is now collecting a frame; the new start word takes effect at the next hunt.
		drain();
		write_start_word(16'hFFFF);

		for (phase = 0; phase < 7; phase++) begin
			if (phase == 0) begin
				start_word = 16'hFFFF;
			end else begin
				drain();
				case (phase)
					1: start_word = 16'h0000;
					3: start_word = 16'h8001;
					5: start_word = 16'hFFFF;
					default: start_word = word_t'($urandom_range(0, 65535));
				endcase
				write_start_word(start_word);
			end
			tx_gaps_on     = (phase % 3) != 1;
			sink_stalls_on = (phase % 3) != 2;
			sent = 0;
			while (sent < 150) begin
				pick = $urandom_range(0, 19);
				if (pick < 15) begin
					send_frame();
					sent += 16;
				end else if (pick < 18) begin
					burst = $urandom_range(1, 4);
					repeat (burst) send_byte(byte_t'($urandom_range(0, 255)));
					sent += burst;
				end else if (pick == 18) begin
					send_byte(start_word[15:8]);
					send_byte(byte_t'($urandom_range(0, 255)));
					sent += 2;
				end else begin
					drain();
				end
			end
		end

		rx_ch.valid <= 1'b0;
		while (frames_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
